[sv/ultrasonic_echo_timer_core_assert.svh]
// assertion macros shared by the echo timer modules
`ifndef ULTRASONIC_ECHO_TIMER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_TIMER_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define UET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uet assertion failed");

// next-cycle implication, checked on every clock outside reset
`define UET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uet assertion failed");

`endif

[sv/uet_pkg.sv]
package uet_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RST_TRIGGER_TICKS  = 16'd7200;
  localparam logic [CFG_DATA_W-1:0] RST_TICKS_PER_UNIT = 16'd400;

  // item fields
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int WIDTH_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TRIGGER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEAS = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;      // take one tick item
    logic div_step;    // one divider iteration
    logic div_finish;  // store the quotient in the result register
  } uet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_go;     // offered item is a read that needs the divider
    logic div_last;    // divider is on its final iteration
  } uet_stat_t;

endpackage

[sv/uet_datapath.sv]
module uet_datapath #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uet_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [uet_pkg::ACTION_W-1:0]      action,
  input  logic                              echo_level,
  input  uet_pkg::uet_cmd_t                 cmd,
  output uet_pkg::uet_stat_t                stat,
  output logic                              trigger_pin,
  output logic [uet_pkg::STATUS_W-1:0]      status,
  output logic [uet_pkg::WIDTH_W-1:0]       echo_width,
  output logic                              reading_valid
);

  localparam int CNT_W = $clog2(TIME_WIDTH + 1);
  localparam int EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 33;
  localparam int DW    = uet_pkg::CFG_DATA_W;

  logic [DW-1:0]         trig_ticks_r, tpu_r;
  logic [TIME_WIDTH-1:0] time_r, start_r, end_r;
  logic [DW-1:0]         trem_r;
  logic                  busy_r, expf_r, prev_r;

  logic [TIME_WIDTH-1:0] start_nxt, end_nxt, diff;
  logic [DW-1:0]         trem_mid, trem_nxt;
  logic                  busy_nxt, expf_nxt, pin;
  logic [uet_pkg::STATUS_W-1:0] status_nxt;
  logic                  read_go;

  logic [TIME_WIDTH-1:0] rq_r, rq_step;
  logic [DW-1:0]         rem_r, rem_step;
  logic [CNT_W-1:0]      cnt_r;
  logic [DW:0]           trial;
  logic                  ge;
  logic [EXT_W-1:0]      quo_ext;
  logic [uet_pkg::WIDTH_W-1:0] width_fin;

  logic                  pin_r, rv_r;
  logic [uet_pkg::STATUS_W-1:0] status_r;
  logic [uet_pkg::WIDTH_W-1:0]  width_r;

  // one tick: echo edge, then request, then trigger pin
  always_comb begin
    start_nxt  = start_r;
    end_nxt    = end_r;
    expf_nxt   = expf_r;
    busy_nxt   = busy_r;
    trem_mid   = trem_r;
    status_nxt = uet_pkg::ST_OK;
    read_go    = 1'b0;
    if (!expf_r) begin
      if (echo_level && !prev_r) begin
        start_nxt = time_r;
        expf_nxt  = 1'b1;
      end
    end else if (!echo_level && prev_r) begin
      end_nxt  = time_r;
      expf_nxt = 1'b0;
      busy_nxt = 1'b0;
    end
    case (action)
      uet_pkg::ACT_TRIGGER: begin
        if (busy_nxt) begin
          status_nxt = uet_pkg::ST_BUSY;
        end else begin
          trem_mid = trig_ticks_r;
          busy_nxt = 1'b1;
        end
      end
      uet_pkg::ACT_READ: begin
        if (busy_nxt) begin
          status_nxt = uet_pkg::ST_BUSY;
        end else if (start_nxt == '0 && end_nxt == '0) begin
          status_nxt = uet_pkg::ST_NO_MEAS;
        end else begin
          read_go = 1'b1;
        end
      end
      default: ;
    endcase
    pin      = (trem_mid != '0);
    trem_nxt = pin ? trem_mid - 1'b1 : trem_mid;
    diff     = end_nxt - start_nxt;
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, rq_r[TIME_WIDTH-1]};
    ge       = (trial >= {1'b0, tpu_r});
    rem_step = ge ? DW'(trial - {1'b0, tpu_r}) : trial[DW-1:0];
    rq_step  = {rq_r[TIME_WIDTH-2:0], ge};
    quo_ext  = EXT_W'(rq_step);
    if (quo_ext[EXT_W-1:32] != '0 || tpu_r == '0) begin
      width_fin = '1;
    end else begin
      width_fin = quo_ext[uet_pkg::WIDTH_W-1:0];
    end
  end

  assign stat.read_go  = read_go;
  assign stat.div_last = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= uet_pkg::RST_TRIGGER_TICKS;
      tpu_r        <= uet_pkg::RST_TICKS_PER_UNIT;
      time_r       <= '0;
      start_r      <= '0;
      end_r        <= '0;
      trem_r       <= '0;
      busy_r       <= 1'b0;
      expf_r       <= 1'b0;
      prev_r       <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uet_pkg::REG_TRIGGER_TICKS:  trig_ticks_r <= cfg_wdata;
          uet_pkg::REG_TICKS_PER_UNIT: tpu_r        <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        time_r  <= time_r + 1'b1;
        start_r <= start_nxt;
        end_r   <= end_nxt;
        trem_r  <= trem_nxt;
        busy_r  <= busy_nxt;
        expf_r  <= expf_nxt;
        prev_r  <= echo_level;
        if (read_go) begin
          cnt_r <= CNT_W'(TIME_WIDTH);
        end
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pin_r    <= pin;
      status_r <= status_nxt;
      rv_r     <= read_go;
      width_r  <= '0;
      rq_r     <= diff;
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      rq_r  <= rq_step;
      rem_r <= rem_step;
      if (cmd.div_finish) begin
        width_r <= width_fin;
      end
    end
  end

  assign trigger_pin   = pin_r;
  assign status        = status_r;
  assign echo_width    = width_r;
  assign reading_valid = rv_r;

  `include "ultrasonic_echo_timer_core_assert.svh"

  `UET_ASSERT_NEXT(a_time_adv, cmd.accept, time_r == TIME_WIDTH'($past(time_r) + 1'b1))
  `UET_ASSERT_NEXT(a_time_hold, !cmd.accept, $stable(time_r) && $stable(trem_r))

endmodule

[sv/uet_ctrl.sv]
module uet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  uet_pkg::uet_stat_t stat,
  output uet_pkg::uet_cmd_t  cmd
);

  typedef enum logic [0:0] {
    S_RUN,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_comb begin
    in_tready      = (state_r == S_RUN) && (!out_valid_r || out_tready);
    accept         = in_tvalid && in_tready;
    cmd.accept     = accept;
    cmd.div_step   = (state_r == S_DIV);
    cmd.div_finish = (state_r == S_DIV) && stat.div_last;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_RUN: begin
        if (accept) begin
          if (stat.read_go) begin
            state_nxt = S_DIV;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt     = S_RUN;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `include "ultrasonic_echo_timer_core_assert.svh"

  `UET_ASSERT_NOW(a_div_blocks_input, state_r == S_DIV, !in_tready && !out_valid_r)
  `UET_ASSERT_NEXT(a_read_enters_div, accept && stat.read_go, state_r == S_DIV && !out_valid_r)
  `UET_ASSERT_NEXT(a_finish_shows_result, cmd.div_finish, out_valid_r && state_r == S_RUN)

endmodule

[sv/ultrasonic_echo_timer_core.sv]
// ultrasonic ranging controller core
//
// input channel: one item per timer tick. in_tuser carries the request
// (plain tick, trigger, read), in_tdata[0] the sampled echo pin level.
// output channel: exactly one item per input item, in order. out_tdata holds
// the trigger pin level and the echo width, out_tuser the status code and the
// reading-valid flag.
// result: a tick, trigger or refused read shows its result in the cycle after it
// is accepted; a read that returns a measurement runs the bit-serial divider
// and shows its result once the final iteration has stored the quotient.
// throughput: one item per cycle for ticks and triggers unless the receiver stalls;
// a successful read holds off the input while the divider runs, one quotient bit per cycle.
// a single output register separates the channels: a new item is taken in the
// cycle the pending result is taken, and a stalled receiver stops the input.
// reset (synchronous, rst_n low) clears the timestamp, echo capture, busy and
// trigger state and loads the register defaults (7200 trigger ticks, divisor 400)
// configuration writes are registered; the user must make them only while idle (unchecked)
module ultrasonic_echo_timer_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [uet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uet_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] echo_level, rest zero
  input  logic [uet_pkg::ACTION_W-1:0]     in_tuser,   // [1:0] action
  // output channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,  // [0] trigger_pin, [32:1] echo_width
  output logic [2:0]                       out_tuser   // [1:0] status, [2] reading_valid
);

  uet_pkg::uet_cmd_t  cmd;
  uet_pkg::uet_stat_t stat;

  logic                          trigger_pin;
  logic [uet_pkg::STATUS_W-1:0]  status;
  logic [uet_pkg::WIDTH_W-1:0]   echo_width;
  logic                          reading_valid;

  // handshake and sequencing
  uet_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // timer, echo capture, trigger pulse, divider and result register
  uet_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .action        (in_tuser),
    .echo_level    (in_tdata[0]),
    .cmd           (cmd),
    .stat          (stat),
    .trigger_pin   (trigger_pin),
    .status        (status),
    .echo_width    (echo_width),
    .reading_valid (reading_valid)
  );

  // pack result fields, lowest first, zero padded to whole bytes
  assign out_tdata = {7'b0, echo_width, trigger_pin};
  assign out_tuser = {reading_valid, status};

endmodule
